@@ rtl/core/htd_pkg.sv @@
package htd_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [8:0]  symbol_count;
    logic [8:0]  symbol_index;
    logic [14:0] code_value;
    logic [3:0]  code_length;
    logic [14:0] stream_bits;
  } req_t;

  typedef struct packed {
    logic [8:0] symbol;
    logic [3:0] bits_used;
    logic       not_found;
  } res_t;

endpackage

@@ rtl/core/huffman_table_decoder.sv @@
// Decode: a fast-table hit passes PEEK (table read) and HIT before the result strobe.
// Fallback: for each length above LOOKUP_BITS, SRCH shifts in one stream bit and CMP
// walks the active symbols (SRCH alone with none active); a miss tries every length.
// Load: busy while 2^(LOOKUP_BITS-len) slots are written, one table slot per cycle; not
// busy without slots. Clear: one sweep of max(2^LOOKUP_BITS, MAX_SYMBOLS) entries; the same
// sweep runs after reset with busy high. One request at a time; results cannot be stalled.
module huffman_table_decoder import htd_pkg::*; #(
  parameter int LOOKUP_BITS   = 9,
  parameter int MAX_CODE_BITS = 15,
  parameter int MAX_SYMBOLS   = 288
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic valid_o,
  output res_t res_o
);
  localparam int TS    = 1 << LOOKUP_BITS;
  localparam int SW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int SWEEP = (TS > MAX_SYMBOLS) ? TS : MAX_SYMBOLS;
  localparam int CW    = $clog2(SWEEP + 1);
  localparam int MAXB  = (LOOKUP_BITS > MAX_CODE_BITS) ? LOOKUP_BITS : MAX_CODE_BITS;

  typedef enum logic [6:0] {
    S_CLR = 7'b0000001, S_IDLE = 7'b0000010, S_LOAD = 7'b0000100,
    S_PEEK = 7'b0001000, S_HIT = 7'b0010000, S_SRCH = 7'b0100000,
    S_CMP = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [9:0]    act_q, act_d;
  req_t          req_q;
  logic [15:0]   code_q, code_d;
  logic [4:0]    len_q, len_d;
  logic          valid_d;
  res_t          res_d, res_q;

  // memories: fast table and code store
  logic [8:0]  ft_sym [TS];
  logic [3:0]  ft_len [TS];
  logic [14:0] cs_code [MAX_SYMBOLS];
  logic [3:0]  cs_len  [MAX_SYMBOLS];
  logic [8:0]  ft_sym_r;
  logic [3:0]  ft_len_r;
  logic [14:0] cs_code_r;
  logic [3:0]  cs_len_r;

  logic          ft_we, cs_we;
  logic [LOOKUP_BITS-1:0] ft_wa, ft_ra;
  logic [8:0]    ft_wsym;
  logic [3:0]    ft_wlen;
  logic [SW-1:0] cs_wa, cs_ra;
  logic [14:0]   cs_wcode;
  logic [3:0]    cs_wlen;

  always_ff @(posedge clk_i) begin
    if (ft_we) begin
      ft_sym[ft_wa] <= ft_wsym;
      ft_len[ft_wa] <= ft_wlen;
    end
    ft_sym_r <= ft_sym[ft_ra];
    ft_len_r <= ft_len[ft_ra];
    if (cs_we) begin
      cs_code[cs_wa] <= cs_wcode;
      cs_len[cs_wa]  <= cs_wlen;
    end
    cs_code_r <= cs_code[cs_ra];
    cs_len_r  <= cs_len[cs_ra];
  end

  function automatic logic [LOOKUP_BITS-1:0] rev(input logic [LOOKUP_BITS-1:0] v);
    logic [LOOKUP_BITS-1:0] r;
    for (int k = 0; k < LOOKUP_BITS; k++) r[k] = v[LOOKUP_BITS-1-k];
    return r;
  endfunction

  logic [3:0]  ld_len;
  logic [14:0] ld_code;
  logic        ld_ok;
  logic [LOOKUP_BITS-1:0] ld_base;
  logic [4:0]  sh;
  logic [CW-1:0] span;
  logic [SW-1:0] idx_c;
  req_t        req_cap;

  always_comb begin
    ld_len  = (32'(req_i.code_length) > MAX_CODE_BITS) ? 4'd0 : req_i.code_length;
    ld_code = req_i.code_value & 15'((16'd1 << ld_len) - 16'd1);
    ld_ok   = (10'(req_i.symbol_index) < act_q) && (32'(req_i.symbol_index) < MAX_SYMBOLS);
    sh      = 5'(LOOKUP_BITS) - 5'(req_q.code_length);
    ld_base = LOOKUP_BITS'(32'(req_q.code_value) << sh);
    span    = CW'(32'd1 << sh);
    idx_c   = cnt_q[SW-1:0];
    // load fields are kept masked; other commands do not use them
    req_cap = req_i;
    req_cap.code_value  = ld_code;
    req_cap.code_length = ld_len;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; act_d = act_q;
    code_d = code_q; len_d = len_q;
    valid_d = 1'b0; res_d = res_q;
    ft_we = 1'b0; ft_wa = cnt_q[LOOKUP_BITS-1:0]; ft_wsym = '0; ft_wlen = '0;
    cs_we = 1'b0; cs_wa = idx_c; cs_wcode = '0; cs_wlen = '0;
    ft_ra = req_q.stream_bits[LOOKUP_BITS-1:0];
    cs_ra = idx_c;
    unique case (state_q)
      S_CLR: begin
        ft_we = 1'b1;
        cs_we = 32'(cnt_q) < MAX_SYMBOLS;
        cnt_d = cnt_q + CW'(1);
        if (32'(cnt_q) == SWEEP - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          unique case (req_i.command)
            CMD_CLEAR: begin
              act_d   = (32'(req_i.symbol_count) > MAX_SYMBOLS) ?
                        10'(MAX_SYMBOLS) : 10'(req_i.symbol_count);
              state_d = S_CLR;
            end
            CMD_LOAD: if (ld_ok) begin
              cs_we = 1'b1; cs_wa = SW'(req_i.symbol_index);
              cs_wcode = ld_code; cs_wlen = ld_len;
              if (ld_len != 0 && 32'(ld_len) <= LOOKUP_BITS) state_d = S_LOAD;
            end
            CMD_DECODE: state_d = S_PEEK;
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        ft_we = 1'b1; ft_wa = rev(ld_base | cnt_q[LOOKUP_BITS-1:0]);
        ft_wsym = req_q.symbol_index; ft_wlen = req_q.code_length;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == span - CW'(1)) state_d = S_IDLE;
      end
      S_PEEK: state_d = S_HIT;  // table read in flight
      S_HIT: begin
        if (ft_len_r != 0) begin
          valid_d = 1'b1;
          res_d = '{symbol: ft_sym_r, bits_used: ft_len_r, not_found: 1'b0};
          state_d = S_IDLE;
        end else begin
          code_d = 16'(rev(req_q.stream_bits[LOOKUP_BITS-1:0]));
          len_d  = 5'(LOOKUP_BITS);
          cnt_d  = '0;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        // next length: shift in a stream bit, restart index walk; miss at max length
        if (32'(len_q) >= MAX_CODE_BITS || act_q == 0) begin
          if (32'(len_q) >= MAX_CODE_BITS) begin
            valid_d = 1'b1;
            res_d = '{symbol: 9'd0, bits_used: 4'(MAXB), not_found: 1'b1};
            state_d = S_IDLE;
          end else begin
            len_d = len_q + 5'd1;
          end
        end else begin
          code_d = {code_q[14:0], req_q.stream_bits[4'(len_q)]};
          len_d  = len_q + 5'd1;
          cnt_d  = '0;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        // cs data for cnt_q-1 arrives in the cycle after address cnt_q-1
        cs_ra = idx_c;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q != 0 && 5'(cs_len_r) == len_q && 16'(cs_code_r) == code_q) begin
          valid_d = 1'b1;
          res_d = '{symbol: 9'(cnt_q - CW'(1)), bits_used: 4'(len_q), not_found: 1'b0};
          state_d = S_IDLE;
        end else if (10'(cnt_q) == act_q) begin
          state_d = S_SRCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
      act_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      act_q   <= act_d;
      valid_o <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    len_q  <= len_d;
    res_q  <= res_d;
    if (state_q == S_IDLE && start_i) begin
      req_q <= req_cap;
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign res_o  = res_q;
endmodule

@@ rtl/core/htd_checker.sv @@
module htd_checker import htd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o,
  input res_t res_o
);
  a_nf_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.not_found |-> res_o.symbol == 9'd0) else $error("nf symbol");
  a_go_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || !valid_o) else $error("start not taken");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("double result");
  a_res_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !res_o.not_found |-> res_o.bits_used != 4'd0) else $error("zero len");
endmodule

bind huffman_table_decoder htd_checker u_htd_checker (.*);

@@ dv/huffman_table_decoder_test.sv @@
`timescale 1ns / 100ps

module huffman_table_decoder_test;
  import htd_pkg::*;

  localparam int LUT_BITS = 9;
  localparam int CODE_BITS = 15;
  localparam int SYMS = 288;
  localparam int LUT_SIZE = 1 << LUT_BITS;
  localparam int ITEM_GOAL = 1650;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 700;
  localparam logic [1:0] CMD_NOP = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic valid_o;
  req_t req_i = '0;
  res_t res_o;

  huffman_table_decoder dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .valid_o(valid_o), .res_o(res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model of the tables
  logic [8:0] lut_sym [LUT_SIZE];
  logic [3:0] lut_len [LUT_SIZE];
  logic [14:0] store_code [SYMS];
  logic [3:0] store_len [SYMS];
  int unsigned active_count;

  res_t expected_symbols[$];
  int fail_count = 0;
  int item_total = 0;
  int decode_total = 0;
  int fast_hits = 0;
  int slow_hits = 0;
  int misses = 0;
  int burst_left = 0;
  longint cycle_count = 0;

  // stimulus side copy of the current canonical codes
  logic [14:0] tb_code [SYMS];
  logic [3:0] tb_len [SYMS];

  function automatic int unsigned flip(int unsigned v, int n);
    int unsigned r;
    r = 0;
    for (int k = 0; k < n; k++) r |= ((v >> k) & 1) << (n - 1 - k);
    return r;
  endfunction

  function automatic req_t mk(logic [1:0] cmd, int unsigned cnt, int unsigned idx,
                              int unsigned code, int unsigned len, int unsigned bits);
    req_t r;
    r.command = cmd;
    r.symbol_count = cnt[8:0];
    r.symbol_index = idx[8:0];
    r.code_value = code[14:0];
    r.code_length = len[3:0];
    r.stream_bits = bits[14:0];
    return r;
  endfunction

  task automatic model_clear(int unsigned cnt);
    for (int k = 0; k < LUT_SIZE; k++) begin
      lut_sym[k] = '0;
      lut_len[k] = '0;
    end
    for (int k = 0; k < SYMS; k++) begin
      store_code[k] = '0;
      store_len[k] = '0;
    end
    active_count = (cnt > SYMS) ? SYMS : cnt;
  endtask

  task automatic model_load(int unsigned idx, int unsigned code, int unsigned len);
    int unsigned base;
    int unsigned slot;
    if (idx >= active_count) return;
    if (len > CODE_BITS) len = 0;
    code &= (1 << len) - 1;
    store_code[idx] = code[14:0];
    store_len[idx] = len[3:0];
    if (len == 0 || len > LUT_BITS) return;
    base = code << (LUT_BITS - len);
    for (int y = 0; y < (1 << (LUT_BITS - len)); y++) begin
      slot = flip(base | y, LUT_BITS);
      lut_sym[slot] = idx[8:0];
      lut_len[slot] = len[3:0];
    end
  endtask

  function automatic res_t decode_symbol(logic [14:0] bits);
    res_t r;
    int unsigned peek;
    int unsigned code;
    peek = bits[LUT_BITS-1:0];
    if (lut_len[peek] != 0) begin
      r.symbol = lut_sym[peek];
      r.bits_used = lut_len[peek];
      r.not_found = 1'b0;
      fast_hits++;
      return r;
    end
    code = flip(peek, LUT_BITS);
    for (int len = LUT_BITS + 1; len <= CODE_BITS; len++) begin
      code = ((code << 1) | bits[len-1]) & 16'hFFFF;
      for (int i = 0; i < active_count; i++) begin
        if (store_len[i] == len && store_code[i] == code) begin
          r.symbol = i[8:0];
          r.bits_used = len[3:0];
          r.not_found = 1'b0;
          slow_hits++;
          return r;
        end
      end
    end
    r.symbol = '0;
    r.bits_used = CODE_BITS[3:0];
    r.not_found = 1'b1;
    misses++;
    return r;
  endfunction

  task automatic send_request(req_t r);
    req_i <= r;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    item_total++;
    case (r.command)
      CMD_CLEAR: model_clear(r.symbol_count);
      CMD_LOAD: model_load(r.symbol_index, r.code_value, r.code_length);
      CMD_DECODE: begin
        expected_symbols.push_back(decode_symbol(r.stream_bits));
        decode_total++;
      end
      default: ;
    endcase
    // bursty sender; some bursts are long enough to run without gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("huffman_table_decoder verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && valid_o) begin
      if (expected_symbols.size() == 0) begin
        $error("unexpected result: symbol %0d bits_used %0d not_found %0d",
               res_o.symbol, res_o.bits_used, res_o.not_found);
        fail_count++;
      end else begin
        exp_r = expected_symbols.pop_front();
        if (res_o.symbol !== exp_r.symbol) begin
          $error("symbol: expected %0d actual %0d", exp_r.symbol, res_o.symbol);
          fail_count++;
        end
        if (res_o.bits_used !== exp_r.bits_used) begin
          $error("bits_used: expected %0d actual %0d", exp_r.bits_used, res_o.bits_used);
          fail_count++;
        end
        if (res_o.not_found !== exp_r.not_found) begin
          $error("not_found: expected %0d actual %0d", exp_r.not_found, res_o.not_found);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(mk(CMD_DECODE, 0, 0, 0, 0, 15'h7FFF));   // empty tables
    send_request(mk(CMD_NOP, 511, 511, 15'h7FFF, 15, 15'h7FFF));
    send_request(mk(CMD_CLEAR, 300, 0, 0, 0, 0));           // saturates
    send_request(mk(CMD_LOAD, 0, 287, 15'h7FFF, 15, 0));
    send_request(mk(CMD_LOAD, 0, 0, 15'h7FFE, 1, 0));      // stray bits above length
    send_request(mk(CMD_LOAD, 0, 1, 15'h7FFE, 2, 0));
    send_request(mk(CMD_LOAD, 0, 2, 3, 2, 0));
    send_request(mk(CMD_DECODE, 0, 0, 0, 0, 0));
    send_request(mk(CMD_DECODE, 0, 0, 0, 0, 15'h7FFF));
    send_request(mk(CMD_DECODE, 0, 0, 0, 0, 15'h0001));
    send_request(mk(CMD_LOAD, 0, 1, 0, 2, 0));             // overlaps symbol 0
    send_request(mk(CMD_LOAD, 0, 1, 3, 2, 0));             // reload keeps old slots
    send_request(mk(CMD_DECODE, 0, 0, 0, 0, 0));
    send_request(mk(CMD_CLEAR, 8, 0, 0, 0, 0));
    send_request(mk(CMD_LOAD, 0, 3, 15'h3FF, 10, 0));
    send_request(mk(CMD_LOAD, 0, 4, 15'h3FF, 10, 0));      // tie with symbol 3
    send_request(mk(CMD_LOAD, 0, 5, 0, 15, 0));
    send_request(mk(CMD_LOAD, 0, 8, 0, 1, 0));             // inactive symbol
    send_request(mk(CMD_LOAD, 0, 511, 0, 1, 0));
    send_request(mk(CMD_LOAD, 0, 6, 0, 0, 0));
    send_request(mk(CMD_DECODE, 0, 0, 0, 0, 15'h7FFF));
    send_request(mk(CMD_DECODE, 0, 0, 0, 0, 0));
    send_request(mk(CMD_DECODE, 0, 0, 0, 0, 15'h5555));
    wait_drained();
  endtask

  task automatic test_random_tables();
    int unsigned cnt, act, pick, nd, j;
    int unsigned len_hist [16];
    int unsigned next_code [16];
    int unsigned bits;
    int table_no;
    table_no = 0;
    while (item_total < ITEM_GOAL) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) cnt = SYMS;
      else if (pick == 1) cnt = $urandom_range(SYMS + 1, 511);
      else if (pick == 2) cnt = $urandom_range(0, 1);
      else cnt = $urandom_range(2, 24);
      send_request(mk(CMD_CLEAR, cnt, $urandom, $urandom, $urandom, $urandom));
      act = (cnt > SYMS) ? SYMS : cnt;
      // canonical codes from random lengths, as a deflate encoder builds them
      for (int k = 0; k < 16; k++) len_hist[k] = 0;
      for (int i = 0; i < act; i++) begin
        tb_len[i] = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        len_hist[tb_len[i]]++;
      end
      len_hist[0] = 0;
      next_code[0] = 0;
      for (int k = 1; k < 16; k++) next_code[k] = (next_code[k-1] + len_hist[k-1]) << 1;
      for (int i = 0; i < act; i++) begin
        if (tb_len[i] != 0) begin
          tb_code[i] = 15'(next_code[tb_len[i]]);
          next_code[tb_len[i]]++;
        end
        send_request(mk(CMD_LOAD, $urandom, i, tb_code[i] | ($urandom << tb_len[i]),
                        tb_len[i], $urandom));
        if ($urandom_range(0, 19) == 0)
          send_request(mk($urandom_range(0, 1) ? CMD_LOAD : CMD_NOP, $urandom,
                          $urandom_range(0, 511), $urandom, $urandom, $urandom));
      end
      nd = $urandom_range(8, 30);
      for (int d = 0; d < nd; d++) begin
        bits = $urandom & 15'h7FFF;
        if (act > 0 && $urandom_range(0, 1)) begin
          j = $urandom_range(0, act - 1);
          if (tb_len[j] != 0) begin
            bits = (bits & ~((1 << tb_len[j]) - 1)) | flip(tb_code[j], tb_len[j]);
          end
        end
        send_request(mk(CMD_DECODE, $urandom, $urandom, $urandom, $urandom, bits));
      end
      table_no++;
      if (table_no % 6 == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_tables();
    wait_drained();
    $display("covered %0d requests, %0d decodes: %0d fast-table hits, %0d fallback hits,",
             item_total, decode_total, fast_hits, slow_hits);
    $display("%0d misses, over clears of empty, small and full alphabets", misses);
    if (fail_count == 0) begin
      $display("huffman_table_decoder verification clean");
    end else begin
      $display("huffman_table_decoder verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/htd_pkg.sv
rtl/core/huffman_table_decoder.sv
rtl/core/htd_checker.sv
dv/huffman_table_decoder_test.sv
